@@ src/lcg_pkg.sv @@
// Shared types and constants for the LED cell colour and glow pipeline.
package lcg_pkg;

    // Brightness fixed point format
    localparam int unsigned FRAC_BITS = 12;
    localparam int unsigned BQ_W      = FRAC_BITS;
    localparam int unsigned SCALE     = 1 << FRAC_BITS;

    // Hue register width
    localparam int unsigned HUE_W = 9;

    // Packed stream widths
    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned M_TDATA_W = 80;

    // Hue sector, in order of increasing hue
    typedef enum logic [2:0] {
        SEC_R_Y = 3'd0,   // red to yellow
        SEC_Y_G = 3'd1,   // yellow to green
        SEC_G_C = 3'd2,   // green to cyan
        SEC_C_B = 3'd3,   // cyan to blue
        SEC_B_M = 3'd4,   // blue to magenta
        SEC_M_R = 3'd5    // magenta to red
    } t_sector;

    // After the front stage
    typedef struct packed {
        logic             lit;
        logic             show;
        t_sector          sector;
        logic [5:0]       k;
        logic [BQ_W-1:0]  bq;
        logic [2*BQ_W-1:0] bq2;
        logic [14:0]      f;      // 5*S - 2*b
        logic [14:0]      num;    // 5*S - d, glow numerator
    } t_front;

    // After the first multiply stage
    typedef struct packed {
        logic              lit;
        logic              show;
        t_sector           sector;
        logic [5:0]        k;
        logic [2*BQ_W-1:0] bq2;
        logic [26:0]       cn;
        logic [7:0]        vc;
        logic [7:0]        vm;
        logic [5:0]        alpha;
        logic [30:0]       lvl_p;
    } t_mid1;

    // After the second multiply stage
    typedef struct packed {
        logic        lit;
        logic        show;
        t_sector     sector;
        logic [7:0]  vc;
        logic [7:0]  vm;
        logic [5:0]  alpha;
        logic [12:0] level;
        logic [32:0] p;
    } t_mid2;

    // After the scaling stage
    typedef struct packed {
        logic        lit;
        logic        show;
        t_sector     sector;
        logic [7:0]  vc;
        logic [7:0]  vm;
        logic [5:0]  alpha;
        logic [12:0] level;
        logic [10:0] q;
    } t_mid3;

endpackage

@@ src/lcg_front.sv @@
// Front stage: hue decode, brightness square, lit and glow decisions.
module lcg_front import lcg_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [BQ_W-1:0]  i_bq,
    input  logic [HUE_W-1:0] i_hue,
    output logic             o_valid,
    input  logic             i_ready,
    output t_front           o_data
);

    logic             r_v;
    t_front           r_data;
    t_front           n_data;
    logic [HUE_W-1:0] hue_w;
    logic [HUE_W-1:0] rem;
    t_sector          sector;
    logic [17:0]      b50;
    logic [16:0]      b20;
    logic [16:0]      c11;
    logic [16:0]      d;
    logic [18:0]      d4;

    // Hue wrap, sector and distance into the sector pair
    always_comb begin
        hue_w = (i_hue >= HUE_W'(360)) ? i_hue - HUE_W'(360) : i_hue;
        if (hue_w < HUE_W'(60)) begin
            sector = SEC_R_Y;
        end else if (hue_w < HUE_W'(120)) begin
            sector = SEC_Y_G;
        end else if (hue_w < HUE_W'(180)) begin
            sector = SEC_G_C;
        end else if (hue_w < HUE_W'(240)) begin
            sector = SEC_C_B;
        end else if (hue_w < HUE_W'(300)) begin
            sector = SEC_B_M;
        end else begin
            sector = SEC_M_R;
        end
        case (sector)
            SEC_R_Y, SEC_Y_G: rem = hue_w;
            SEC_G_C, SEC_C_B: rem = hue_w - HUE_W'(120);
            default:          rem = hue_w - HUE_W'(240);
        endcase
    end

    // Payload for the multiply stages
    always_comb begin
        b50 = 18'(i_bq) * 18'd50;
        b20 = 17'(i_bq) * 17'd20;
        c11 = 17'(11 * SCALE);
        d   = (b20 >= c11) ? b20 - c11 : c11 - b20;
        d4  = {d, 2'b00};

        n_data.sector = sector;
        n_data.k      = (rem >= HUE_W'(60)) ? 6'(HUE_W'(120) - rem) : 6'(rem);
        n_data.bq     = i_bq;
        n_data.bq2    = (2*BQ_W)'(i_bq) * (2*BQ_W)'(i_bq);
        n_data.f      = 15'(5 * SCALE) - 15'({i_bq, 1'b0});
        n_data.lit    = (b50 >= 18'(SCALE));
        n_data.show   = n_data.lit && (d4 < 19'(19 * SCALE));
        n_data.num    = 15'(17'(5 * SCALE) - d);
    end

    // Stage register
    assign o_ready = !r_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_v;
    assign o_data  = r_data;

endmodule

@@ src/lcg_mul.sv @@
// Multiply stages: channel products, middle channel numerator and its scaling.
module lcg_mul import lcg_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_front i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_mid3  o_data
);

    logic   r_vb, r_vc, r_vd;
    logic   rdy_b, rdy_c, rdy_d;
    t_mid1  r_b, n_b;
    t_mid2  r_c, n_c;
    t_mid3  r_d, n_d;

    // Stage B: full and floor channels, c numerator, glow products
    always_comb begin
        n_b.lit    = i_data.lit;
        n_b.show   = i_data.show;
        n_b.sector = i_data.sector;
        n_b.k      = i_data.k;
        n_b.bq2    = i_data.bq2;
        n_b.cn     = 27'(i_data.bq) * 27'(i_data.f);
        n_b.vc     = 8'((20'(i_data.bq) * 20'd255) >> FRAC_BITS);
        n_b.vm     = 8'((31'(i_data.bq2) * 31'd102) >> (2*FRAC_BITS));
        n_b.alpha  = 6'((18'(i_data.num) * 18'd12) >> FRAC_BITS);
        // num / 5 through reciprocal 52429 / 2^18
        n_b.lvl_p  = 31'(i_data.num) * 31'd52429;
    end

    // Stage C: c*k + 120*b^2
    always_comb begin
        n_c.lit    = r_b.lit;
        n_c.show   = r_b.show;
        n_c.sector = r_b.sector;
        n_c.vc     = r_b.vc;
        n_c.vm     = r_b.vm;
        n_c.alpha  = r_b.alpha;
        n_c.level  = 13'(r_b.lvl_p >> 18);
        n_c.p      = 33'(r_b.cn) * 33'(r_b.k) + 33'(r_b.bq2) * 33'd120;
    end

    // Stage D: 17*p / 2^26, the divide by 5 follows in the output stage
    always_comb begin
        n_d.lit    = r_c.lit;
        n_d.show   = r_c.show;
        n_d.sector = r_c.sector;
        n_d.vc     = r_c.vc;
        n_d.vm     = r_c.vm;
        n_d.alpha  = r_c.alpha;
        n_d.level  = r_c.level;
        n_d.q      = 11'((37'(r_c.p) * 37'd17) >> (2*FRAC_BITS + 2));
    end

    // Per stage flow control, bubbles are squeezed out
    assign rdy_d   = !r_vd || i_ready;
    assign rdy_c   = !r_vc || rdy_d;
    assign rdy_b   = !r_vb || rdy_c;
    assign o_ready = rdy_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (rdy_b) begin
                r_vb <= i_valid;
            end
            if (rdy_c) begin
                r_vc <= r_vb;
            end
            if (rdy_d) begin
                r_vd <= r_vc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_b && i_valid) begin
            r_b <= n_b;
        end
        if (rdy_c && r_vb) begin
            r_c <= n_c;
        end
        if (rdy_d && r_vc) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_vd;
    assign o_data  = r_d;

endmodule

@@ src/lcg_out.sv @@
// Output stage: middle channel, sector routing, glow colour and output register.
module lcg_out import lcg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_mid3                i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [M_TDATA_W-1:0] o_tdata
);

    logic                 r_v;
    logic [M_TDATA_W-1:0] r_tdata;
    logic [M_TDATA_W-1:0] n_tdata;
    logic [8:0]           vx9;
    logic [7:0]           vx;
    logic [7:0]           red, grn, blu, lalpha;
    logic [8:0]           gred9;
    logic [7:0]           gred, ggrn, gblu;
    logic [5:0]           galpha;
    logic [12:0]          level;

    always_comb begin
        // q / 5 through reciprocal 3277 / 2^14
        vx9 = 9'((23'(i_data.q) * 23'd3277) >> 14);
        vx  = (vx9 > 9'd255) ? 8'd255 : vx9[7:0];

        case (i_data.sector)
            SEC_R_Y: begin
                red = i_data.vc; grn = vx;         blu = i_data.vm;
            end
            SEC_Y_G: begin
                red = vx;        grn = i_data.vc;  blu = i_data.vm;
            end
            SEC_G_C: begin
                red = i_data.vm; grn = i_data.vc;  blu = vx;
            end
            SEC_C_B: begin
                red = i_data.vm; grn = vx;         blu = i_data.vc;
            end
            SEC_B_M: begin
                red = vx;        grn = i_data.vm;  blu = i_data.vc;
            end
            default: begin
                red = i_data.vc; grn = i_data.vm;  blu = vx;
            end
        endcase
        lalpha = 8'd255;

        // Glow colour, red lifted by 40 and saturated
        gred9  = 9'(red) + 9'd40;
        gred   = (gred9 > 9'd255) ? 8'd255 : gred9[7:0];
        ggrn   = grn;
        gblu   = 8'd255;
        galpha = i_data.alpha;
        level  = i_data.level;

        // Dark cell clears everything, weak glow clears the glow fields
        if (!i_data.lit) begin
            red = '0; grn = '0; blu = '0; lalpha = '0;
        end
        if (!(i_data.lit && i_data.show)) begin
            gred = '0; ggrn = '0; gblu = '0; galpha = '0; level = '0;
        end

        n_tdata = {5'd0, level, galpha, gblu, ggrn, gred, lalpha, blu, grn, red};
    end

    // Output register
    assign o_ready = !r_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_tdata <= n_tdata;
        end
    end

    assign o_valid = r_v;
    assign o_tdata = r_tdata;

    // Glow only on a lit cell
    a_glow_needs_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v && r_tdata[55:48] != 8'd0) |-> (r_tdata[31:24] == 8'd255))
        else $error("glow shown on a dark cell");

    // Glow opacity stays within 0..60
    a_alpha_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v |-> (r_tdata[61:56] <= 6'd60))
        else $error("glow alpha out of range");

    // Glow red never below LED red when the glow is shown
    a_glow_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v && r_tdata[55:48] == 8'd255) |-> (r_tdata[39:32] >= r_tdata[7:0]))
        else $error("glow red below led red");

    // No glow means no glow level
    a_level_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v && r_tdata[55:48] == 8'd0) |-> (r_tdata[74:62] == 13'd0))
        else $error("glow level set without glow");

endmodule

@@ src/led_cell_color_and_glow.sv @@
// Each cell passes the front, B, C, D and output registers in turn. Throughput: one
// cell per cycle while m_axis_tready is high; every stage has its own valid bit, so
// bubbles close up under back-pressure and a held result stalls only the full stages
// behind it. The depth is set by the chain of products b*b, b*(5S-2b) and c*k ahead
// of the divide by five. Reset clears all valid bits and the hue register to 0.
module led_cell_color_and_glow import lcg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [HUE_W-1:0]     i_cfg_wdata,     // hue_degrees
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,    // [11:0] brightness
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [7:0] led_red, [15:8] led_green, [23:16] led_blue, [31:24] led_alpha,
    // [39:32] glow_red, [47:40] glow_green, [55:48] glow_blue,
    // [61:56] glow_alpha, [74:62] glow_level
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic [HUE_W-1:0] r_hue;
    logic             front_v, front_rdy;
    t_front           front_d;
    logic             mul_v, mul_rdy;
    t_mid3            mul_d;

    // Hue register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue <= '0;
        end else if (i_cfg_we) begin
            r_hue <= i_cfg_wdata;
        end
    end

    lcg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_bq    (s_axis_tdata[BQ_W-1:0]),
        .i_hue   (r_hue),
        .o_valid (front_v),
        .i_ready (front_rdy),
        .o_data  (front_d)
    );

    lcg_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_v),
        .o_ready (front_rdy),
        .i_data  (front_d),
        .o_valid (mul_v),
        .i_ready (mul_rdy),
        .o_data  (mul_d)
    );

    lcg_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mul_v),
        .o_ready (mul_rdy),
        .i_data  (mul_d),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_tdata (m_axis_tdata)
    );

endmodule
